[src/srec_pkg.sv]
// Package with character codes, status codes and the hex digit decoder for the S-record checker.
package srec_pkg;

    // Character codes used by the line parser.
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_F    = 8'h46;

    // Status codes; the first error seen on a line is the one reported.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_SYNTAX   = 2'd2;
    localparam logic [1:0] STATUS_COUNT    = 2'd3;

    // Character position saturates here.
    localparam logic [9:0] POS_MAX = 10'd1023;

    // Checksum base value.
    localparam logic [7:0] CHECK_BASE = 8'hFF;

    // Width of the packed result word.
    localparam int unsigned RESULT_BITS = 48;

    // Decoded hex digit: valid flag and value (zero when not a digit).
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    // Uppercase-only hex decode of one ASCII character.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        logic [7:0] diff;
        d    = '0;
        diff = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            diff    = c - CHAR_ZERO;
            d.ok    = 1'b1;
            d.value = diff[3:0];
        end
        else if (c >= CHAR_A && c <= CHAR_F)
        begin
            diff    = c - CHAR_A + 8'd10;
            d.ok    = 1'b1;
            d.value = diff[3:0];
        end
        return d;
    endfunction

endpackage

[src/srec_line_checker.sv]
// Streaming checker for one S-record line, one ASCII character per item.
// The result of a line appears in the cycle after its last character is accepted.
// Throughput: one character per cycle while no result waits untaken; the parser state
// updates in the cycle a character is accepted, the result register when a last one is.
// Reset: rst_n clears the parser state and the result valid flag asynchronously.
// After each last character the parser returns to its reset state for the next line.
module srec_line_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // line_last
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [5:2] record_type, [37:6] load_address, [45:38] byte_count, [47:46] zero
    output logic [srec_pkg::RESULT_BITS-1:0] m_tdata
);
    import srec_pkg::*;

    // Parser state.
    logic [9:0]  pos_reg,     pos_next;
    logic [3:0]  kind_reg,    kind_next;
    logic [3:0]  digits_reg,  digits_next;
    logic [7:0]  count_reg,   count_next;
    logic [31:0] addr_reg,    addr_next;
    logic [3:0]  high_reg,    high_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [7:0]  check_reg,   check_next;
    logic [1:0]  error_reg,   error_next;

    // Result register.
    logic        out_valid_reg;
    logic [RESULT_BITS-1:0] out_data_reg;

    logic        accept;
    hex_digit_t  dig;
    logic [1:0]  step_error;
    logic [1:0]  err_a;
    logic [1:0]  final_error;
    logic [10:0] end_pos;
    logic [10:0] end_pos_new;
    logic [10:0] pos_wide;
    logic [10:0] addr_end;
    logic [7:0]  min_count;
    logic [7:0]  pair_byte;

    // A taken result frees its register; characters enter every cycle while none waits.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign dig       = hex_decode(s_tdata);
    assign pos_wide  = {1'b0, pos_reg};
    assign end_pos   = 11'd3 + {2'b00, count_reg, 1'b0};
    assign addr_end  = 11'd4 + {7'd0, digits_reg};
    assign pair_byte = {high_reg, dig.value};

    // Per-character parse of the current position.
    always_comb
    begin
        kind_next   = kind_reg;
        digits_next = digits_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        high_next   = high_reg;
        sum_next    = sum_reg;
        check_next  = check_reg;
        step_error  = STATUS_OK;
        min_count   = 8'd0;

        if (pos_reg == 10'd0)
        begin
            if (s_tdata != CHAR_S)
                step_error = STATUS_SYNTAX;
        end
        else if (pos_reg == 10'd1)
        begin
            kind_next   = dig.value;
            digits_next = 4'd4;
            if (dig.ok && dig.value <= 4'd9 && dig.value != 4'd4)
            begin
                if (dig.value == 4'd2 || dig.value == 4'd6 || dig.value == 4'd8)
                    digits_next = 4'd6;
                else if (dig.value == 4'd3 || dig.value == 4'd7)
                    digits_next = 4'd8;
            end
            else
            begin
                step_error = STATUS_SYNTAX;
            end
        end
        else if (pos_reg <= 10'd3)
        begin
            // Byte count digits, which also enter the checksum.
            count_next = {count_reg[3:0], dig.value};
            if (pos_reg[0])
                sum_next = sum_reg + pair_byte;
            else
                high_next = dig.value;
            min_count = {5'd0, digits_reg[3:1]} + 8'd1;
            if (!dig.ok)
                step_error = STATUS_SYNTAX;
            else if (pos_reg[0] && count_next < min_count)
                step_error = STATUS_COUNT;
        end
        else if (pos_wide < addr_end)
        begin
            // Address digits.
            addr_next = {addr_reg[27:0], dig.value};
            if (pos_reg[0])
                sum_next = sum_reg + pair_byte;
            else
                high_next = dig.value;
            if (!dig.ok)
                step_error = STATUS_SYNTAX;
        end
        else if (pos_wide > end_pos)
        begin
            // Character beyond the length given by the count.
            step_error = STATUS_COUNT;
        end
        else if (pos_wide + 11'd1 >= end_pos)
        begin
            // Checksum digits.
            if (pos_wide + 11'd1 == end_pos)
                high_next = dig.value;
            else
                check_next = pair_byte;
            if (!dig.ok)
                step_error = STATUS_SYNTAX;
        end
        else
        begin
            // Data digits.
            if (pos_reg[0])
                sum_next = sum_reg + pair_byte;
            else
                high_next = dig.value;
            if (!dig.ok)
                step_error = STATUS_COUNT;
        end
    end

    // Error merge: keep the first error, then add the line-end checks.
    assign end_pos_new = 11'd3 + {2'b00, count_next, 1'b0};

    always_comb
    begin
        err_a       = (error_reg != STATUS_OK) ? error_reg : step_error;
        final_error = err_a;
        if (final_error == STATUS_OK && pos_wide != end_pos_new)
            final_error = STATUS_COUNT;
        if (final_error == STATUS_OK && check_next != (CHECK_BASE - sum_next))
            final_error = STATUS_CHECKSUM;
    end

    assign error_next = err_a;
    assign pos_next   = (pos_reg < POS_MAX) ? pos_reg + 10'd1 : pos_reg;

    // Parser state registers; the last character of a line returns them to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            kind_reg   <= '0;
            digits_reg <= '0;
            count_reg  <= '0;
            addr_reg   <= '0;
            high_reg   <= '0;
            sum_reg    <= '0;
            check_reg  <= '0;
            error_reg  <= STATUS_OK;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                pos_reg    <= '0;
                kind_reg   <= '0;
                digits_reg <= '0;
                count_reg  <= '0;
                addr_reg   <= '0;
                high_reg   <= '0;
                sum_reg    <= '0;
                check_reg  <= '0;
                error_reg  <= STATUS_OK;
            end
            else
            begin
                pos_reg    <= pos_next;
                kind_reg   <= kind_next;
                digits_reg <= digits_next;
                count_reg  <= count_next;
                addr_reg   <= addr_next;
                high_reg   <= high_next;
                sum_reg    <= sum_next;
                check_reg  <= check_next;
                error_reg  <= error_next;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && s_tlast)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
            out_data_reg <= {2'b00, count_next, addr_next, kind_next, final_error};
    end

endmodule
